/* sv/ftp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ftp_pkg;

  // Item kinds carried on the input tuser
  localparam logic [2:0] FUNC_TICK        = 3'd0;
  localparam logic [2:0] FUNC_REMOTE_MODE = 3'd1;
  localparam logic [2:0] FUNC_REMOTE_UP   = 3'd2;
  localparam logic [2:0] FUNC_REMOTE_LOW  = 3'd3;
  localparam logic [2:0] FUNC_REMOTE_FAN  = 3'd4;

  // Accepted button press codes
  localparam logic [2:0] EVT_NONE = 3'd0;
  localparam logic [2:0] EVT_MODE = 3'd1;
  localparam logic [2:0] EVT_OK   = 3'd2;
  localparam logic [2:0] EVT_UP   = 3'd3;
  localparam logic [2:0] EVT_DOWN = 3'd4;

  // Panel screens
  localparam logic [1:0] SCR_MAIN  = 2'd0;
  localparam logic [1:0] SCR_UPPER = 2'd1;
  localparam logic [1:0] SCR_LOWER = 2'd2;

  // Configuration register index (byte address bit 2)
  localparam logic REG_DEBOUNCE = 1'b0;

  // Reset values
  localparam logic [15:0]       DEBOUNCE_RESET = 16'd200;
  localparam logic signed [7:0] UPPER_RESET    = 8'sd30;
  localparam logic signed [7:0] LOWER_RESET    = 8'sd25;
  localparam logic signed [7:0] LIMIT_MAX      = 8'sd127;
  localparam logic signed [7:0] LIMIT_MIN      = -8'sd128;
  localparam logic [15:0]       COUNT_MAX      = 16'hFFFF;

  // Input item payload, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]        pad;
    logic signed [7:0] remote_value;
    logic signed [11:0] temperature;
    logic              temp_valid;
    logic              down_button;
    logic              up_button;
    logic              ok_button;
    logic              mode_button;
  } in_item_t;

  // Result item payload, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0]         pad;
    logic [2:0]         button_event;
    logic signed [11:0] temperature_held;
    logic signed [7:0]  lower_edit;
    logic signed [7:0]  upper_edit;
    logic signed [7:0]  lower_now;
    logic signed [7:0]  upper_now;
    logic [1:0]         screen_now;
    logic               auto_mode;
    logic               fan_on;
  } out_item_t;

endpackage

`default_nettype wire

/* sv/fan_thermostat_panel_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Cooling-fan controller with a four-button panel (mode/cancel, ok, up, down).
// Each input item is a millisecond tick (tuser 0) with button levels and an
// optional temperature, or a remote write of mode, upper limit, lower limit or
// fan (tuser 1..4). One shared debounce checks the buttons in the order mode,
// ok, up, down and takes at most one level change per tick, once more than
// debounce_ms ticks have passed since the last change. Every item yields one
// result item with the full panel state after it and the accepted press, if
// any. The next state is computed from the item and the state registers and
// lands in the state and the output register at the same edge, so a new item
// is accepted every cycle while the output register is empty or being
// drained; the result appears in the cycle after accept. debounce_ms sits at
// byte address 0 of the APB port and should only be written while no item is
// in flight.
module fan_thermostat_panel_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: mode_button, ok_button, up_button, down_button, temp_valid,
  //        temperature[11:0], remote_value[7:0], zero fill
  input  wire logic [31:0] s_tdata,
  // tuser: func[2:0]
  input  wire logic [2:0]  s_tuser,
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: fan_on, auto_mode, screen_now[1:0], upper_now[7:0], lower_now[7:0],
  //        upper_edit[7:0], lower_edit[7:0], temperature_held[11:0],
  //        button_event[2:0], zero fill
  output logic [55:0]      m_tdata,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ftp_pkg::in_item_t  in_item;
  ftp_pkg::out_item_t out_item;
  ftp_pkg::out_item_t res_next;

  logic [15:0]        debounce_ms;
  logic               fan_state, fan_next;
  logic               mode_state, mode_next;
  logic [1:0]         screen_state, screen_next;
  logic signed [7:0]  upper_commit, upper_next;
  logic signed [7:0]  lower_commit, lower_next;
  logic signed [7:0]  upper_pending, upper_pend_next;
  logic signed [7:0]  lower_pending, lower_pend_next;
  logic signed [11:0] last_temperature, temp_next;
  logic               last_level, level_next;
  logic [15:0]        ms_count, count_next;

  logic               accept;
  logic [15:0]        count_inc;
  logic [3:0]         levels;
  logic [3:0]         differ;
  logic [2:0]         event_code;
  logic               change_ok;
  logic signed [12:0] temp_ext;
  logic signed [12:0] upper_ext;
  logic signed [12:0] lower_ext;
  logic signed [12:0] upper_x10;
  logic signed [12:0] lower_x10;

  assign in_item  = ftp_pkg::in_item_t'(s_tdata);
  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign m_tdata  = out_item;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ftp_pkg::REG_DEBOUNCE) ? {16'd0, debounce_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= ftp_pkg::DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ftp_pkg::REG_DEBOUNCE) begin
      debounce_ms <= pwdata[15:0];
    end
  end

  // Shared debounce: first button whose level differs from the last one wins
  assign count_inc = (ms_count == ftp_pkg::COUNT_MAX) ? ms_count : ms_count + 16'd1;
  assign levels    = {in_item.down_button, in_item.up_button,
                      in_item.ok_button, in_item.mode_button};
  assign differ    = levels ^ {4{last_level}};
  assign change_ok = (s_tuser == ftp_pkg::FUNC_TICK) && (count_inc > debounce_ms) &&
                     (differ != 4'd0);

  always_comb begin
    event_code = ftp_pkg::EVT_NONE;
    // a change to level 0 is a press; a release only blocks the others
    if (change_ok && last_level) begin
      if (differ[0])      event_code = ftp_pkg::EVT_MODE;
      else if (differ[1]) event_code = ftp_pkg::EVT_OK;
      else if (differ[2]) event_code = ftp_pkg::EVT_UP;
      else                event_code = ftp_pkg::EVT_DOWN;
    end
  end

  // Next panel state
  always_comb begin
    fan_next        = fan_state;
    mode_next       = mode_state;
    screen_next     = screen_state;
    upper_next      = upper_commit;
    lower_next      = lower_commit;
    upper_pend_next = upper_pending;
    lower_pend_next = lower_pending;
    temp_next       = last_temperature;
    level_next      = last_level;
    count_next      = ms_count;

    case (s_tuser)
      ftp_pkg::FUNC_TICK: begin
        count_next = count_inc;
        if (in_item.temp_valid) temp_next = in_item.temperature;
        if (change_ok) begin
          count_next = 16'd0;
          level_next = !last_level;
        end
        case (event_code)
          ftp_pkg::EVT_MODE: begin
            if (screen_state == ftp_pkg::SCR_MAIN) begin
              mode_next = !mode_state;
            end else begin
              screen_next     = ftp_pkg::SCR_MAIN;
              upper_pend_next = upper_commit;
              lower_pend_next = lower_commit;
            end
          end
          ftp_pkg::EVT_OK: begin
            if (screen_state == ftp_pkg::SCR_MAIN) begin
              screen_next = ftp_pkg::SCR_UPPER;
            end else if (screen_state == ftp_pkg::SCR_UPPER) begin
              screen_next = ftp_pkg::SCR_LOWER;
              upper_next  = upper_pending;
            end else if (screen_state == ftp_pkg::SCR_LOWER) begin
              screen_next = ftp_pkg::SCR_MAIN;
              lower_next  = lower_pending;
            end
          end
          ftp_pkg::EVT_UP, ftp_pkg::EVT_DOWN: begin
            if (!mode_state && screen_state == ftp_pkg::SCR_MAIN) begin
              fan_next = (event_code == ftp_pkg::EVT_UP);
            end else if (screen_state == ftp_pkg::SCR_UPPER) begin
              // step the edited value, saturate at the 8-bit range
              if (event_code == ftp_pkg::EVT_UP) begin
                if (upper_pending != ftp_pkg::LIMIT_MAX) upper_pend_next = upper_pending + 8'sd1;
              end else begin
                if (upper_pending != ftp_pkg::LIMIT_MIN) upper_pend_next = upper_pending - 8'sd1;
              end
            end else if (screen_state == ftp_pkg::SCR_LOWER) begin
              if (event_code == ftp_pkg::EVT_UP) begin
                if (lower_pending != ftp_pkg::LIMIT_MAX) lower_pend_next = lower_pending + 8'sd1;
              end else begin
                if (lower_pending != ftp_pkg::LIMIT_MIN) lower_pend_next = lower_pending - 8'sd1;
              end
            end
          end
          default: ;
        endcase
      end
      ftp_pkg::FUNC_REMOTE_MODE: mode_next = (in_item.remote_value != 8'sd0);
      ftp_pkg::FUNC_REMOTE_UP: begin
        upper_next = in_item.remote_value;
        if (screen_state == ftp_pkg::SCR_MAIN) upper_pend_next = in_item.remote_value;
      end
      ftp_pkg::FUNC_REMOTE_LOW: begin
        lower_next = in_item.remote_value;
        if (screen_state == ftp_pkg::SCR_MAIN) lower_pend_next = in_item.remote_value;
      end
      ftp_pkg::FUNC_REMOTE_FAN: fan_next = (in_item.remote_value != 8'sd0);
      default: ;
    endcase

    // Hysteresis control on the updated state; upper test first
    if (mode_next) begin
      if (temp_ext >= upper_x10)      fan_next = 1'b1;
      else if (temp_ext <= lower_x10) fan_next = 1'b0;
    end
  end

  // Limits in tenths: L*10 = L*8 + L*2
  assign temp_ext  = {temp_next[11], temp_next};
  assign upper_ext = {{5{upper_next[7]}}, upper_next};
  assign lower_ext = {{5{lower_next[7]}}, lower_next};
  assign upper_x10 = (upper_ext <<< 3) + (upper_ext <<< 1);
  assign lower_x10 = (lower_ext <<< 3) + (lower_ext <<< 1);

  always_comb begin
    res_next                  = '0;
    res_next.fan_on           = fan_next;
    res_next.auto_mode        = mode_next;
    res_next.screen_now       = screen_next;
    res_next.upper_now        = upper_next;
    res_next.lower_now        = lower_next;
    res_next.upper_edit       = upper_pend_next;
    res_next.lower_edit       = lower_pend_next;
    res_next.temperature_held = temp_next;
    res_next.button_event     = event_code;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_state        <= 1'b0;
      mode_state       <= 1'b0;
      screen_state     <= ftp_pkg::SCR_MAIN;
      upper_commit     <= ftp_pkg::UPPER_RESET;
      lower_commit     <= ftp_pkg::LOWER_RESET;
      upper_pending    <= ftp_pkg::UPPER_RESET;
      lower_pending    <= ftp_pkg::LOWER_RESET;
      last_temperature <= 12'sd0;
      last_level       <= 1'b1;
      ms_count         <= 16'd0;
    end else if (accept) begin
      fan_state        <= fan_next;
      mode_state       <= mode_next;
      screen_state     <= screen_next;
      upper_commit     <= upper_next;
      lower_commit     <= lower_next;
      upper_pending    <= upper_pend_next;
      lower_pending    <= lower_pend_next;
      last_temperature <= temp_next;
      last_level       <= level_next;
      ms_count         <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_item <= res_next;
  end

  // Remote writes never report a press
  a_remote_no_event: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser != ftp_pkg::FUNC_TICK |=>
      m_tvalid && out_item.button_event == ftp_pkg::EVT_NONE)
    else $error("remote item reported a button press");

  // An accepted press restarts the debounce count
  a_press_clears_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_item.button_event == ftp_pkg::EVT_NONE || ms_count == 16'd0))
    else $error("press accepted without debounce restart");

  // In automatic mode a temperature at or above the upper limit runs the fan
  a_auto_upper: assert property (@(posedge clk) disable iff (rst)
    accept |=> (!out_item.auto_mode ||
                $signed({out_item.temperature_held[11], out_item.temperature_held}) <
                  ($signed({{5{out_item.upper_now[7]}}, out_item.upper_now}) <<< 3) +
                  ($signed({{5{out_item.upper_now[7]}}, out_item.upper_now}) <<< 1) ||
                out_item.fan_on))
    else $error("fan off above upper limit in automatic mode");

endmodule

`default_nettype wire
